// ===== hdl/mvea_pkg.sv =====
// ----------------------------------------------------------------------------
// mvea_pkg - shared codes for the masked vector element ALU
// Operation, compare, result type and register index codes.
// ----------------------------------------------------------------------------
package mvea_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned WideWidth = 64;
   localparam int unsigned AddrWidth = 5;

   // operation codes (register 0); codes ten and up are undefined
   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_FMA    = 4'd3;
   localparam logic [3:0] OP_MAX    = 4'd4;
   localparam logic [3:0] OP_MIN    = 4'd5;
   localparam logic [3:0] OP_CMP    = 4'd6;
   localparam logic [3:0] OP_SELECT = 4'd7;
   localparam logic [3:0] OP_CLAMP  = 4'd8;
   localparam logic [3:0] OP_RELU   = 4'd9;

   // compare modes (register 1)
   localparam logic [2:0] CMP_EQ = 3'd0;
   localparam logic [2:0] CMP_NE = 3'd1;
   localparam logic [2:0] CMP_LT = 3'd2;
   localparam logic [2:0] CMP_LE = 3'd3;
   localparam logic [2:0] CMP_GT = 3'd4;
   localparam logic [2:0] CMP_GE = 3'd5;

   // result types (register 4)
   localparam logic [1:0] TYPE_INT4  = 2'd0;
   localparam logic [1:0] TYPE_INT8  = 2'd1;
   localparam logic [1:0] TYPE_INT16 = 2'd2;
   localparam logic [1:0] TYPE_INT32 = 2'd3;

   // register indexes (byte address 4 * index)
   localparam logic [2:0] REG_OPERATION   = 3'd0;
   localparam logic [2:0] REG_CMP_KIND    = 3'd1;
   localparam logic [2:0] REG_CLAMP_LOW   = 3'd2;
   localparam logic [2:0] REG_CLAMP_HIGH  = 3'd3;
   localparam logic [2:0] REG_RESULT_TYPE = 3'd4;
   localparam logic [2:0] REG_WRAP_MODE   = 3'd5;
   localparam logic [2:0] REG_MASK_MODE   = 3'd6;

   typedef struct packed {
      logic [3:0] operation;
      logic [2:0] cmp_kind;
      logic [1:0] result_type;
      logic       wrap_mode;
      logic [1:0] mask_mode;
   } ctrl_type;

endpackage

// ===== hdl/masked_vector_element_alu_unit.sv =====
// ----------------------------------------------------------------------------
// masked_vector_element_alu_unit - per-element integer vector ALU
// Add, sub, mul, fma, max, min, compare, select, clamp and relu on one
// element, with mask handling and a saturating or wrapping cast.
// ----------------------------------------------------------------------------
//
// channel   | ports                               | handshake
// ----------+-------------------------------------+---------------------------
// request   | req_operand_a/b/c, req_mask_byte,   | start high, busy low
//           | req_old_dest                        |
// result    | rsp_result_value, rsp_status        | rsp_valid strobe, 1 cycle
// config    | psel penable pwrite paddr pwdata    | APB, pready tied high
//           | prdata pready                       |
//
// One request per cycle; busy stays low. Two registers: the input register,
// then the result register. The 32x32 multiply, the 64-bit fma add
// and the saturation compare of the cast set the longest path between them.
// Reset clears the valid pipeline and the configuration registers. The
// receiver cannot stall, so nothing holds back: each result shows on the
// rsp_ ports for exactly one cycle.
// ----------------------------------------------------------------------------
module masked_vector_element_alu_unit
   import mvea_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  logic signed [DataWidth-1:0] req_operand_a,
   input  logic signed [DataWidth-1:0] req_operand_b,
   input  logic signed [DataWidth-1:0] req_operand_c,
   input  logic signed [7:0]           req_mask_byte,
   input  logic signed [DataWidth-1:0] req_old_dest,
   // result channel
   output logic                        rsp_valid,
   output logic signed [DataWidth-1:0] rsp_result_value,
   output logic                        rsp_status,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [AddrWidth-1:0]        paddr,
   input  logic [DataWidth-1:0]        pwdata,
   output logic [DataWidth-1:0]        prdata,
   output logic                        pready
);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   ctrl_type                    ctrl_ff, ctrl_in;
   logic signed [DataWidth-1:0] clamp_low_ff, clamp_low_in;
   logic signed [DataWidth-1:0] clamp_high_ff, clamp_high_in;
   logic                        cfg_write;
   logic [2:0]                  cfg_index;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;
   assign cfg_index = paddr[AddrWidth-1:2];

   always_comb begin
      ctrl_in       = ctrl_ff;
      clamp_low_in  = clamp_low_ff;
      clamp_high_in = clamp_high_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_OPERATION:   ctrl_in.operation   = pwdata[3:0];
            REG_CMP_KIND:    ctrl_in.cmp_kind    = pwdata[2:0];
            REG_CLAMP_LOW:   clamp_low_in        = pwdata;
            REG_CLAMP_HIGH:  clamp_high_in       = pwdata;
            REG_RESULT_TYPE: ctrl_in.result_type = pwdata[1:0];
            REG_WRAP_MODE:   ctrl_in.wrap_mode   = pwdata[0];
            REG_MASK_MODE:   ctrl_in.mask_mode   = pwdata[1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.operation   <= OP_ADD;
         ctrl_ff.cmp_kind    <= CMP_EQ;
         ctrl_ff.result_type <= TYPE_INT32;
         ctrl_ff.wrap_mode   <= 1'b0;
         ctrl_ff.mask_mode   <= 2'd0;
         clamp_low_ff        <= {1'b1, {(DataWidth-1){1'b0}}};
         clamp_high_ff       <= {1'b0, {(DataWidth-1){1'b1}}};
      end else begin
         ctrl_ff       <= ctrl_in;
         clamp_low_ff  <= clamp_low_in;
         clamp_high_ff <= clamp_high_in;
      end
   end

   // read back, narrow registers zero extended
   always_comb begin
      unique case (cfg_index)
         REG_OPERATION:   prdata = {28'd0, ctrl_ff.operation};
         REG_CMP_KIND:    prdata = {29'd0, ctrl_ff.cmp_kind};
         REG_CLAMP_LOW:   prdata = clamp_low_ff;
         REG_CLAMP_HIGH:  prdata = clamp_high_ff;
         REG_RESULT_TYPE: prdata = {30'd0, ctrl_ff.result_type};
         REG_WRAP_MODE:   prdata = {31'd0, ctrl_ff.wrap_mode};
         REG_MASK_MODE:   prdata = {30'd0, ctrl_ff.mask_mode};
         default:         prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Input register. Always ready, so every start is a request.
   // -------------------------------------------------------------------------
   logic                        s1_valid_ff;
   logic signed [DataWidth-1:0] a_ff, b_ff, c_ff, old_ff;
   logic                        mask_zero_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         a_ff         <= req_operand_a;
         b_ff         <= req_operand_b;
         c_ff         <= req_operand_c;
         old_ff       <= req_old_dest;
         mask_zero_ff <= (req_mask_byte == 8'sd0);
      end
   end

   // -------------------------------------------------------------------------
   // Arithmetic, exact in 64 bits, then mask substitution
   // -------------------------------------------------------------------------
   logic signed [WideWidth-1:0] a_w, b_w, c_w, old_w, lo_w, hi_w;
   logic signed [WideWidth-1:0] product, value_in;
   logic                        status_in;
   logic                        masked_off, cmp_hit;

   assign a_w     = WideWidth'(a_ff);
   assign b_w     = WideWidth'(b_ff);
   assign c_w     = WideWidth'(c_ff);
   assign old_w   = WideWidth'(old_ff);
   assign lo_w    = WideWidth'(clamp_low_ff);
   assign hi_w    = WideWidth'(clamp_high_ff);
   assign product = a_w * b_w;

   // mode three acts as keep-old
   assign masked_off = (ctrl_ff.mask_mode != 2'd0) & mask_zero_ff;

   always_comb begin
      unique case (ctrl_ff.cmp_kind)
         CMP_EQ:  cmp_hit = (a_ff == b_ff);
         CMP_NE:  cmp_hit = (a_ff != b_ff);
         CMP_LT:  cmp_hit = (a_ff <  b_ff);
         CMP_LE:  cmp_hit = (a_ff <= b_ff);
         CMP_GT:  cmp_hit = (a_ff >  b_ff);
         CMP_GE:  cmp_hit = (a_ff >= b_ff);
         default: cmp_hit = 1'b0;
      endcase
   end

   always_comb begin
      status_in = 1'b0;
      unique case (ctrl_ff.operation)
         OP_ADD:    value_in = a_w + b_w;
         OP_SUB:    value_in = a_w - b_w;
         OP_MUL:    value_in = product;
         OP_FMA:    value_in = product + c_w;
         OP_MAX:    value_in = (a_ff > b_ff) ? a_w : b_w;
         OP_MIN:    value_in = (a_ff < b_ff) ? a_w : b_w;
         OP_CMP:    value_in = {{(WideWidth-1){1'b0}}, cmp_hit};
         OP_SELECT: value_in = masked_off ? a_w : b_w;
         OP_CLAMP: begin
            if (clamp_low_ff > clamp_high_ff) begin
               status_in = 1'b1;
               value_in  = '0;
            end else if (a_ff < clamp_low_ff) begin
               value_in = lo_w;
            end else if (a_ff > clamp_high_ff) begin
               value_in = hi_w;
            end else begin
               value_in = a_w;
            end
         end
         OP_RELU:   value_in = a_ff[DataWidth-1] ? '0 : a_w;
         default: begin
            status_in = 1'b1;
            value_in  = '0;
         end
      endcase
      // masked-off lanes: zero or keep destination (select handles its own)
      if (!status_in && ctrl_ff.operation != OP_SELECT && masked_off) begin
         value_in = ctrl_ff.mask_mode[1] ? old_w : '0;
      end
   end

   // -------------------------------------------------------------------------
   // Cast to result type, saturating or wrapping, into the result register
   // -------------------------------------------------------------------------
   logic signed [WideWidth-1:0] sat_hi, sat_lo;
   logic signed [DataWidth-1:0] wrapped, result_in, rsp_result_value_ff;
   logic                        rsp_status_ff, rsp_valid_ff;

   always_comb begin
      unique case (ctrl_ff.result_type)
         TYPE_INT4: begin
            sat_hi  = 64'sd7;
            sat_lo  = -64'sd8;
            wrapped = {{28{value_in[3]}}, value_in[3:0]};
         end
         TYPE_INT8: begin
            sat_hi  = 64'sd127;
            sat_lo  = -64'sd128;
            wrapped = {{24{value_in[7]}}, value_in[7:0]};
         end
         TYPE_INT16: begin
            sat_hi  = 64'sd32767;
            sat_lo  = -64'sd32768;
            wrapped = {{16{value_in[15]}}, value_in[15:0]};
         end
         TYPE_INT32: begin
            sat_hi  = 64'sd2147483647;
            sat_lo  = -64'sd2147483648;
            wrapped = value_in[DataWidth-1:0];
         end
         default: begin
            sat_hi  = 64'sd2147483647;
            sat_lo  = -64'sd2147483648;
            wrapped = value_in[DataWidth-1:0];
         end
      endcase
   end

   always_comb begin
      priority if (status_in) begin
         result_in = '0;
      end else if (ctrl_ff.wrap_mode) begin
         result_in = wrapped;
      end else if (value_in > sat_hi) begin
         result_in = sat_hi[DataWidth-1:0];
      end else if (value_in < sat_lo) begin
         result_in = sat_lo[DataWidth-1:0];
      end else begin
         result_in = value_in[DataWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rsp_result_value_ff <= result_in;
         rsp_status_ff       <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_value_ff;
   assign rsp_status       = rsp_status_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> s1_valid_ff)
      else $error("request not captured in input stage");

   a_two_cycle_latency: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_valid)
      else $error("result strobe missing one cycle after input stage");

   a_error_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_result_value == '0)
      else $error("error status with nonzero result");

   a_int8_sign_extended: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ctrl_ff.result_type == TYPE_INT8 |->
         (rsp_result_value[31:7] == '0 || rsp_result_value[31:7] == '1))
      else $error("int8 result not sign extended");

   a_int4_sign_extended: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ctrl_ff.result_type == TYPE_INT4 |->
         (rsp_result_value[31:3] == '0 || rsp_result_value[31:3] == '1))
      else $error("int4 result not sign extended");

endmodule

// ===== tb/mvea_element_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvea_element_checker - result predictor and scoreboard for the element ALU
// Snoops the APB register writes and the request channel, works out each
// expected element and compares it with what the unit strobes out.
// ----------------------------------------------------------------------------
module mvea_element_checker
   import mvea_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic signed [DataWidth-1:0] req_operand_a,
   input  logic signed [DataWidth-1:0] req_operand_b,
   input  logic signed [DataWidth-1:0] req_operand_c,
   input  logic signed [7:0]           req_mask_byte,
   input  logic signed [DataWidth-1:0] req_old_dest,
   input  logic                        rsp_valid,
   input  logic signed [DataWidth-1:0] rsp_result_value,
   input  logic                        rsp_status,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic                        pready,
   input  logic [AddrWidth-1:0]        paddr,
   input  logic [DataWidth-1:0]        pwdata,
   output int                          mismatch_count,
   output int                          results_outstanding
);

   typedef struct packed {
      logic signed [DataWidth-1:0] value;
      logic                        status;
   } alu_element_type;

   ctrl_type                    live_ctrl;
   logic signed [DataWidth-1:0] live_clamp_low;
   logic signed [DataWidth-1:0] live_clamp_high;
   alu_element_type             expected_elements[$];
   int                          fail_tally = 0;

   assign mismatch_count = fail_tally;

   // exact 64-bit arithmetic, then mask handling and the cast
   function automatic alu_element_type predict_element(
      input logic signed [DataWidth-1:0] a,
      input logic signed [DataWidth-1:0] b,
      input logic signed [DataWidth-1:0] c,
      input logic [7:0]                  mask,
      input logic signed [DataWidth-1:0] old);
      longint          sa, sb, sc, so, v, hi, lo, clo, chi;
      int unsigned     width;
      logic            masked_off;
      alu_element_type r;
      sa = a;
      sb = b;
      sc = c;
      so = old;
      clo = live_clamp_low;
      chi = live_clamp_high;
      masked_off = (live_ctrl.mask_mode != 2'd0) && (mask == 8'd0);
      v = 0;
      r.status = 1'b0;
      case (live_ctrl.operation)
         OP_ADD:    v = sa + sb;
         OP_SUB:    v = sa - sb;
         OP_MUL:    v = sa * sb;
         OP_FMA:    v = sa * sb + sc;
         OP_MAX:    v = (sa > sb) ? sa : sb;
         OP_MIN:    v = (sa < sb) ? sa : sb;
         OP_CMP: begin
            case (live_ctrl.cmp_kind)
               CMP_EQ:  v = (sa == sb);
               CMP_NE:  v = (sa != sb);
               CMP_LT:  v = (sa < sb);
               CMP_LE:  v = (sa <= sb);
               CMP_GT:  v = (sa > sb);
               CMP_GE:  v = (sa >= sb);
               default: v = 0;
            endcase
         end
         OP_SELECT: v = masked_off ? sa : sb;
         OP_CLAMP: begin
            if (clo > chi) begin
               r.status = 1'b1;
            end else begin
               v = (sa < clo) ? clo : ((sa > chi) ? chi : sa);
            end
         end
         OP_RELU:   v = (sa < 0) ? 0 : sa;
         default:   r.status = 1'b1;
      endcase
      if (r.status) begin
         v = 0;
      end else begin
         if (live_ctrl.operation != OP_SELECT && masked_off) begin
            v = live_ctrl.mask_mode[1] ? so : 0;
         end
         width = 4 << live_ctrl.result_type;
         hi = (64'sd1 <<< (width - 1)) - 1;
         lo = -hi - 1;
         if (live_ctrl.wrap_mode) begin
            v = (v <<< (64 - width)) >>> (64 - width);
         end else if (v > hi) begin
            v = hi;
         end else if (v < lo) begin
            v = lo;
         end
      end
      r.value = v[DataWidth-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      alu_element_type want;
      if (reset) begin
         live_ctrl.operation   <= OP_ADD;
         live_ctrl.cmp_kind    <= CMP_EQ;
         live_ctrl.result_type <= TYPE_INT32;
         live_ctrl.wrap_mode   <= 1'b0;
         live_ctrl.mask_mode   <= 2'd0;
         live_clamp_low        <= 32'sh80000000;
         live_clamp_high       <= 32'sh7fffffff;
         expected_elements.delete();
         results_outstanding   <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[AddrWidth-1:2])
               REG_OPERATION:   live_ctrl.operation   <= pwdata[3:0];
               REG_CMP_KIND:    live_ctrl.cmp_kind    <= pwdata[2:0];
               REG_CLAMP_LOW:   live_clamp_low        <= pwdata;
               REG_CLAMP_HIGH:  live_clamp_high       <= pwdata;
               REG_RESULT_TYPE: live_ctrl.result_type <= pwdata[1:0];
               REG_WRAP_MODE:   live_ctrl.wrap_mode   <= pwdata[0];
               REG_MASK_MODE:   live_ctrl.mask_mode   <= pwdata[1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_elements.size() == 0) begin
               $error("unexpected result: result_value %0d status %0d",
                      rsp_result_value, rsp_status);
               fail_tally++;
            end else begin
               want = expected_elements.pop_front();
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, actual %0d",
                         want.value, rsp_result_value);
                  fail_tally++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_tally++;
               end
            end
         end
         if (start && !busy) begin
            expected_elements.push_back(predict_element(req_operand_a, req_operand_b,
                                                        req_operand_c, req_mask_byte,
                                                        req_old_dest));
         end
         results_outstanding <= expected_elements.size();
      end
   end

endmodule

// ===== tb/masked_vector_element_alu_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_vector_element_alu_unit_tb - stimulus and verdict for the element ALU
// Runs a directed pass over every operation, compare mode, mask mode and cast,
// then random phases under fresh register settings with varied sender gaps.
// The checker beside the unit predicts and scores every result.
// ----------------------------------------------------------------------------
module masked_vector_element_alu_unit_tb;
   import mvea_pkg::*;

   localparam int CycleLimit    = 200000;
   localparam int PipeLatency   = 6;     // two stages, with margin
   localparam int PhaseCount    = 14;
   localparam int PhaseRequests = 43;

   // sender idle chance per cycle, in percent
   localparam int IdleNone   = 0;
   localparam int IdleSender = 83;
   localparam int IdleBoth   = 16;

   localparam logic [3:0] OP_UNDEF_LO = 4'd10;
   localparam logic [3:0] OP_UNDEF_HI = 4'd15;
   localparam logic [2:0] CMP_UNDEF_A = 3'd6;
   localparam logic [2:0] CMP_UNDEF_B = 3'd7;
   localparam logic       SAT         = 1'b0;
   localparam logic       WRAP        = 1'b1;
   localparam logic [1:0] MASK_OFF      = 2'd0;
   localparam logic [1:0] MASK_ZERO     = 2'd1;
   localparam logic [1:0] MASK_KEEP     = 2'd2;
   localparam logic [1:0] MASK_KEEP_ALT = 2'd3;

   localparam logic signed [DataWidth-1:0] MaxInt = 32'sh7fffffff;
   localparam logic signed [DataWidth-1:0] MinInt = 32'sh80000000;

   typedef struct packed {
      logic [3:0]                  op;
      logic [2:0]                  cmp;
      logic signed [DataWidth-1:0] lo;
      logic signed [DataWidth-1:0] hi;
      logic [1:0]                  rtype;
      logic                        ovf;
      logic [1:0]                  mmode;
   } alu_setting_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [DataWidth-1:0] req_operand_a;
   logic signed [DataWidth-1:0] req_operand_b;
   logic signed [DataWidth-1:0] req_operand_c;
   logic signed [7:0]           req_mask_byte;
   logic signed [DataWidth-1:0] req_old_dest;
   logic                        rsp_valid;
   logic signed [DataWidth-1:0] rsp_result_value;
   logic                        rsp_status;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [AddrWidth-1:0]        paddr;
   logic [DataWidth-1:0]        pwdata;
   logic [DataWidth-1:0]        prdata;
   logic                        pready;
   int                          mismatch_count;
   int                          results_outstanding;
   int                          cycle_count = 0;

   masked_vector_element_alu_unit uut (.*);

   mvea_element_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the unit hangs or drops results
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic alu_setting_type make_setting(
      input logic [3:0] op, input logic [2:0] cmp,
      input logic signed [DataWidth-1:0] lo, input logic signed [DataWidth-1:0] hi,
      input logic [1:0] rtype, input logic ovf, input logic [1:0] mmode);
      alu_setting_type s;
      s.op    = op;
      s.cmp   = cmp;
      s.lo    = lo;
      s.hi    = hi;
      s.rtype = rtype;
      s.ovf   = ovf;
      s.mmode = mmode;
      return s;
   endfunction

   // mix small values (so narrow casts do not always saturate), corners,
   // 16-bit values and full-width random words
   function automatic logic signed [DataWidth-1:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 40) - 20;
         1: return $urandom_range(0, 300) - 150;
         2: begin
            case ($urandom_range(0, 3))
               0:       return MaxInt;
               1:       return MinInt;
               2:       return 0;
               default: return -1;
            endcase
         end
         3:       return $signed(16'($urandom()));
         default: return $urandom();
      endcase
   endfunction

   function automatic alu_setting_type rand_setting();
      alu_setting_type s;
      logic signed [DataWidth-1:0] x, y;
      x = rand_operand();
      y = rand_operand();
      // undefined operation codes now and then
      if ($urandom_range(0, 9) == 0) begin
         s.op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      end else begin
         s.op = 4'($urandom_range(OP_ADD, OP_RELU));
      end
      s.cmp   = 3'($urandom_range(CMP_EQ, CMP_UNDEF_B));
      s.rtype = 2'($urandom_range(TYPE_INT4, TYPE_INT32));
      s.ovf   = 1'($urandom_range(SAT, WRAP));
      s.mmode = 2'($urandom_range(MASK_OFF, MASK_KEEP_ALT));
      case ($urandom_range(0, 3))
         0: begin
            s.lo = MinInt;
            s.hi = MaxInt;
         end
         1: begin
            // either order, so an inverted range shows up too
            s.lo = x;
            s.hi = y;
         end
         2: begin
            s.lo = (x < y) ? x : y;
            s.hi = (x < y) ? y : x;
         end
         default: begin
            s.lo = -int'($urandom_range(0, 60));
            s.hi = $urandom_range(0, 60);
         end
      endcase
      return s;
   endfunction

   // lower start and hold until every expected result is back, then let the
   // pipeline settle
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
      repeat (PipeLatency) @(posedge clock);
   endtask

   // program all seven registers while the unit is idle
   task automatic apply_setting(input alu_setting_type s);
      logic [DataWidth-1:0] reg_data [7];
      drain_results();
      reg_data[REG_OPERATION]   = 32'(s.op);
      reg_data[REG_CMP_KIND]    = 32'(s.cmp);
      reg_data[REG_CLAMP_LOW]   = s.lo;
      reg_data[REG_CLAMP_HIGH]  = s.hi;
      reg_data[REG_RESULT_TYPE] = 32'(s.rtype);
      reg_data[REG_WRAP_MODE]   = 32'(s.ovf);
      reg_data[REG_MASK_MODE]   = 32'(s.mmode);
      for (int i = REG_OPERATION; i <= REG_MASK_MODE; i++) begin
         // setup cycle, then access cycle; psel stays high between writes
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= AddrWidth'(i * 4);
         pwdata  <= reg_data[i];
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // idle at random, then present one request and hold it until accepted;
   // start is left high so back-to-back requests never drop it
   task automatic send_element(
      input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b,
      input logic signed [DataWidth-1:0] c, input logic signed [7:0] m,
      input logic signed [DataWidth-1:0] old, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      req_operand_c <= c;
      req_mask_byte <= m;
      req_old_dest  <= old;
      do @(posedge clock); while (busy);
   endtask

   task automatic directed_element(
      input alu_setting_type s,
      input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b,
      input logic signed [DataWidth-1:0] c, input logic signed [7:0] m,
      input logic signed [DataWidth-1:0] old);
      apply_setting(s);
      send_element(a, b, c, m, old, IdleNone);
   endtask

   initial begin
      alu_setting_type s;
      int              idle_pct;
      int              pause_at;

      // drive every input to a known value before the first edge
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operand_a <= '0;
      req_operand_b <= '0;
      req_operand_c <= '0;
      req_mask_byte <= '0;
      req_old_dest  <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: saturation and wrap at the int32 edges ----
      directed_element(make_setting(OP_ADD, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), MaxInt, MaxInt, 0, 8'sh7f, 0);
      directed_element(make_setting(OP_ADD, CMP_EQ, MinInt, MaxInt, TYPE_INT32, WRAP,
                                    MASK_OFF), MaxInt, MaxInt, 0, 8'sh7f, 0);
      directed_element(make_setting(OP_SUB, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), MinInt, MaxInt, 0, 8'sh01, 0);
      directed_element(make_setting(OP_MUL, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), MinInt, MinInt, 0, 8'sh01, 0);
      directed_element(make_setting(OP_FMA, CMP_EQ, MinInt, MaxInt, TYPE_INT16, WRAP,
                                    MASK_OFF), MinInt, MaxInt, MinInt, 8'sh01, 0);
      directed_element(make_setting(OP_MAX, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), -1, 0, 0, 8'sh01, 0);
      directed_element(make_setting(OP_MIN, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), MinInt, MaxInt, 0, 8'sh01, 0);

      // every compare mode, the two undefined ones included (they give zero)
      for (int k = CMP_EQ; k <= CMP_UNDEF_B; k++) begin
         directed_element(make_setting(OP_CMP, 3'(k), MinInt, MaxInt, TYPE_INT32, SAT,
                                       MASK_OFF), -7, k[0] ? -7 : 4, 0, 8'sh01, 0);
      end

      // select: with masking off the mask counts as nonzero, so operand b wins
      directed_element(make_setting(OP_SELECT, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), 11, 22, 0, 8'sh00, 33);
      directed_element(make_setting(OP_SELECT, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_ZERO), 11, 22, 0, 8'sh00, 33);

      // clamp into a narrow range, then an inverted range with a zero mask
      directed_element(make_setting(OP_CLAMP, CMP_EQ, -100, 100, TYPE_INT8, SAT,
                                    MASK_OFF), MaxInt, 0, 0, 8'sh01, 0);
      directed_element(make_setting(OP_CLAMP, CMP_EQ, 5, -5, TYPE_INT32, SAT,
                                    MASK_ZERO), 3, 0, 0, 8'sh00, 77);
      directed_element(make_setting(OP_RELU, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), MinInt, 0, 0, 8'sh01, 0);

      // undefined operations flag status and give zero
      directed_element(make_setting(OP_UNDEF_LO, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_OFF), 5, 6, 7, 8'sh01, 8);
      directed_element(make_setting(OP_UNDEF_HI, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_KEEP), 5, 6, 7, 8'sh00, 8);

      // masked-off elements: zero, keep old (saturated to int4), mode three
      // behaving as keep (wrapped to int4)
      directed_element(make_setting(OP_ADD, CMP_EQ, MinInt, MaxInt, TYPE_INT32, SAT,
                                    MASK_ZERO), 5, 6, 0, 8'sh00, 99);
      directed_element(make_setting(OP_ADD, CMP_EQ, MinInt, MaxInt, TYPE_INT4, SAT,
                                    MASK_KEEP), 5, 6, 0, 8'sh00, MaxInt);
      directed_element(make_setting(OP_ADD, CMP_EQ, MinInt, MaxInt, TYPE_INT4, WRAP,
                                    MASK_KEEP_ALT), 5, 6, 0, 8'sh00, MinInt);

      // int8 wrap with a negative (nonzero) mask byte
      directed_element(make_setting(OP_ADD, CMP_EQ, MinInt, MaxInt, TYPE_INT8, WRAP,
                                    MASK_ZERO), 127, 1, 0, 8'sh80, 0);

      // ---- random phases: each operation gets a phase of its own first ----
      for (int p = 0; p < PhaseCount; p++) begin
         s = rand_setting();
         if (p <= OP_RELU) s.op = 4'(p);
         case (p % 3)
            0:       idle_pct = IdleNone;
            1:       idle_pct = IdleSender;
            default: idle_pct = IdleBoth;
         endcase
         apply_setting(s);
         pause_at = $urandom_range(5, PhaseRequests - 5);
         for (int n = 0; n < PhaseRequests; n++) begin
            // stop feeding once per phase until the pipeline is empty
            if (n == pause_at) drain_results();
            send_element(rand_operand(), rand_operand(), rand_operand(),
                         ($urandom_range(0, 9) < 4) ? 8'sh00 : 8'($urandom_range(1, 255)),
                         rand_operand(), idle_pct);
         end
      end

      // wait out every outstanding result plus the pipeline depth
      drain_results();
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
